/* hdl/ray_cylinder_intersect_assert.svh */
// Assertion macros for the ray/cylinder intersection block.
// Used by the top level; expects signals clk and rst in scope.
`ifndef RAY_CYLINDER_INTERSECT_ASSERT_SVH
`define RAY_CYLINDER_INTERSECT_ASSERT_SVH

// Overlapping implication, checked on every rising edge outside reset.
`define RCI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RCI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rci_pkg.sv */
// Package for the ray/cylinder intersection block: Q16.16 types,
// saturating arithmetic helpers and pipeline sizes. No dependencies.
`timescale 1ns / 1ps
package rci_pkg;

  localparam int DW  = 32;               // datapath width
  localparam int FB  = 16;               // fraction bits
  localparam int RTW = (DW + FB) / 2;    // square root bits
  localparam int QW  = DW + FB;          // quotient bits

  typedef logic signed [DW-1:0]   dw_t;
  typedef logic        [DW-2:0]   uq_t;
  typedef logic signed [2*DW-1:0] wide_t;

  localparam dw_t DW_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam dw_t DW_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam dw_t EPS_Q  = dw_t'((64'd1 << FB) / 64'd1000000);

  function automatic dw_t sat_wide(input wide_t v);
    logic [DW:0] top;
    top = v[2*DW-1:DW-1];
    if ((&top) || !(|top)) return v[DW-1:0];
    return v[2*DW-1] ? DW_MIN : DW_MAX;
  endfunction

  function automatic dw_t sadd(input dw_t a, input dw_t b);
    wide_t s;
    s = wide_t'(a) + wide_t'(b);
    return sat_wide(s);
  endfunction

  function automatic dw_t ssub(input dw_t a, input dw_t b);
    wide_t s;
    s = wide_t'(a) - wide_t'(b);
    return sat_wide(s);
  endfunction

  // Exact product, floor shift by FB, saturate.
  function automatic dw_t mulq(input dw_t a, input dw_t b);
    wide_t p;
    p = a * b;
    return sat_wide(p >>> FB);
  endfunction

endpackage

/* hdl/rci_sqrt.sv */
// Pipelined integer square root: floor(sqrt(val * 2^FB)), one root bit per stage.
// Depends on rci_pkg.
`timescale 1ns / 1ps
module rci_sqrt (
  input  logic                       clk,
  input  rci_pkg::uq_t               val,
  output logic [rci_pkg::RTW-1:0]    root
);
  import rci_pkg::*;

  localparam int SXW = 2 * RTW;
  localparam int RMW = RTW + 2;

  logic [SXW-1:0] xs  [0:RTW];
  logic [RMW-1:0] rem [0:RTW];
  logic [RTW-1:0] rt  [0:RTW];

  assign xs[0]  = SXW'({val, {FB{1'b0}}});
  assign rem[0] = '0;
  assign rt[0]  = '0;

  for (genvar k = 0; k < RTW; k++) begin : g_step
    logic [RMW+1:0] rem4, trial;
    logic           ge;
    assign rem4  = {rem[k], xs[k][SXW-1:SXW-2]};
    assign trial = (RMW+2)'({rt[k], 2'b01});
    assign ge    = rem4 >= trial;
    always_ff @(posedge clk) begin
      xs[k+1]  <= {xs[k][SXW-3:0], 2'b00};
      rem[k+1] <= RMW'(ge ? rem4 - trial : rem4);
      rt[k+1]  <= {rt[k][RTW-2:0], ge};
    end
  end

  assign root = rt[RTW];

endmodule

/* hdl/rci_div.sv */
// Pipelined signed divide: (num * 2^FB) / den, den positive, truncated, saturated.
// Restoring, one quotient bit per stage. Depends on rci_pkg.
`timescale 1ns / 1ps
module rci_div (
  input  logic          clk,
  input  rci_pkg::dw_t  num,
  input  rci_pkg::uq_t  den,
  output rci_pkg::dw_t  quo
);
  import rci_pkg::*;

  logic [QW-1:0] dvd [0:QW];
  logic [DW-2:0] rem [0:QW];
  logic [QW-1:0] q   [0:QW];
  uq_t           dn  [0:QW];
  logic          ng  [0:QW];
  logic [DW-1:0] mag;

  assign mag    = num[DW-1] ? DW'(-num) : DW'(num);
  assign dvd[0] = {mag, {FB{1'b0}}};
  assign rem[0] = '0;
  assign q[0]   = '0;
  assign dn[0]  = den;
  assign ng[0]  = num[DW-1];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] rem2;
    logic          ge;
    assign rem2 = {rem[k], dvd[k][QW-1]};
    assign ge   = rem2 >= {1'b0, dn[k]};
    always_ff @(posedge clk) begin
      dvd[k+1] <= {dvd[k][QW-2:0], 1'b0};
      rem[k+1] <= (DW-1)'(ge ? rem2 - {1'b0, dn[k]} : rem2);
      q[k+1]   <= {q[k][QW-2:0], ge};
      dn[k+1]  <= dn[k];
      ng[k+1]  <= ng[k];
    end
  end

  logic over;
  dw_t  low;
  assign over = |q[QW][QW-1:DW-1];
  assign low  = {1'b0, q[QW][DW-2:0]};

  always_ff @(posedge clk) begin
    if (ng[QW]) begin
      quo <= over ? DW_MIN : dw_t'(-low);
    end else begin
      quo <= over ? DW_MAX : low;
    end
  end

endmodule

/* hdl/ray_cylinder_intersect.sv */
// Ray vs infinite cylinder test, Q16.16. One start transfer accepted per cycle,
// busy is never set.
// Rate set by the fully pipelined datapath: 10 arithmetic stages, a 24-stage
// square root and two 49-stage restoring dividers running side by side.
// rst is synchronous: clears valid bits and loads the register reset values.
// The receiver cannot stall; each result shows for one cycle with done high.
`timescale 1ns / 1ps
`include "ray_cylinder_intersect_assert.svh"
module ray_cylinder_intersect (
  input  logic          clk,
  input  logic          rst,
  // item channel
  input  logic          start,
  output logic          busy,
  input  rci_pkg::dw_t  origin_x,
  input  rci_pkg::dw_t  origin_y,
  input  rci_pkg::dw_t  origin_z,
  input  rci_pkg::dw_t  dir_x,
  input  rci_pkg::dw_t  dir_y,
  input  rci_pkg::dw_t  dir_z,
  input  rci_pkg::uq_t  nearest_in,
  // result channel
  output logic          done,
  output logic          hit,
  output rci_pkg::uq_t  nearest_out,
  // register port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import rci_pkg::*;

  typedef enum logic [2:0] {
    R_BASE_X, R_BASE_Y, R_BASE_Z, R_AXIS_X, R_AXIS_Y, R_AXIS_Z, R_RADIUS_SQ
  } reg_idx_t;

  localparam int PRE = 10;             // front arithmetic stages
  localparam int DVL = QW + 1;         // divider latency
  localparam int LAT = PRE + RTW + 1 + DVL + 1;

  // ---------------- registers ----------------
  dw_t base_x, base_y, base_z, axis_x, axis_y, axis_z;
  uq_t radius_squared;
  logic     wr_en;
  reg_idx_t widx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x         <= '0;
      base_y         <= '0;
      base_z         <= '0;
      axis_x         <= '0;
      axis_y         <= dw_t'(1 << FB);
      axis_z         <= '0;
      radius_squared <= uq_t'(1 << FB);
    end else if (wr_en) begin
      case (widx)
        R_BASE_X:    base_x         <= pwdata;
        R_BASE_Y:    base_y         <= pwdata;
        R_BASE_Z:    base_z         <= pwdata;
        R_AXIS_X:    axis_x         <= pwdata;
        R_AXIS_Y:    axis_y         <= pwdata;
        R_AXIS_Z:    axis_z         <= pwdata;
        R_RADIUS_SQ: radius_squared <= pwdata[DW-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      R_BASE_X:    prdata = base_x;
      R_BASE_Y:    prdata = base_y;
      R_BASE_Z:    prdata = base_z;
      R_AXIS_X:    prdata = axis_x;
      R_AXIS_Y:    prdata = axis_y;
      R_AXIS_Z:    prdata = axis_z;
      R_RADIUS_SQ: prdata = {1'b0, radius_squared};
      default:     prdata = '0;
    endcase
  end

  // ---------------- front pipeline ----------------
  assign busy = 1'b0;

  dw_t org [3], dir [3], bas [3], ax [3];
  assign org = '{origin_x, origin_y, origin_z};
  assign dir = '{dir_x, dir_y, dir_z};
  assign bas = '{base_x, base_y, base_z};
  assign ax  = '{axis_x, axis_y, axis_z};

  logic [PRE-1:0] vld;
  uq_t  near [1:PRE];

  // s1: origin relative to base
  dw_t oc1 [3], d1 [3];
  // s2: projections onto the axis, per lane
  dw_t oc2 [3], d2 [3], pd2 [3], po2 [3];
  // s3: axial lengths
  dw_t oc3 [3], d3 [3], dd3, od3;
  // s4: axial vectors
  dw_t oc4 [3], d4 [3], qd4 [3], qo4 [3];
  // s5: radial parts
  dw_t av5 [3], cv5 [3];
  // s6: dot product terms
  dw_t paa6 [3], pac6 [3], pcc6 [3];
  // s7..s10: quadratic coefficients and discriminant
  dw_t a7, h7, cc7, a8, b8, c8, a9, b9, ac9, bb9;
  dw_t disc10, den10, nb10;
  logic ok10;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PRE-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    near[1] <= nearest_in;
    for (int i = 2; i <= PRE; i++) near[i] <= near[i-1];

    for (int i = 0; i < 3; i++) begin
      oc1[i]  <= ssub(org[i], bas[i]);
      d1[i]   <= dir[i];
      oc2[i]  <= oc1[i];
      d2[i]   <= d1[i];
      pd2[i]  <= mulq(d1[i], ax[i]);
      po2[i]  <= mulq(oc1[i], ax[i]);
      oc3[i]  <= oc2[i];
      d3[i]   <= d2[i];
      oc4[i]  <= oc3[i];
      d4[i]   <= d3[i];
      qd4[i]  <= mulq(ax[i], dd3);
      qo4[i]  <= mulq(ax[i], od3);
      av5[i]  <= ssub(d4[i], qd4[i]);
      cv5[i]  <= ssub(oc4[i], qo4[i]);
      paa6[i] <= mulq(av5[i], av5[i]);
      pac6[i] <= mulq(av5[i], cv5[i]);
      pcc6[i] <= mulq(cv5[i], cv5[i]);
    end
    dd3 <= sadd(sadd(pd2[0], pd2[1]), pd2[2]);
    od3 <= sadd(sadd(po2[0], po2[1]), po2[2]);

    a7  <= sadd(sadd(paa6[0], paa6[1]), paa6[2]);
    h7  <= sadd(sadd(pac6[0], pac6[1]), pac6[2]);
    cc7 <= sadd(sadd(pcc6[0], pcc6[1]), pcc6[2]);

    a8  <= a7;
    b8  <= sadd(h7, h7);
    c8  <= ssub(cc7, dw_t'({1'b0, radius_squared}));

    a9  <= a8;
    b9  <= b8;
    ac9 <= mulq(a8, c8);
    bb9 <= mulq(b8, b8);

    // 4ac saturates the same as two saturating doublings
    disc10 <= ssub(bb9, sat_wide(wide_t'(ac9) <<< 2));
    den10  <= sadd(a9, a9);
    nb10   <= ssub('0, b9);
    ok10   <= a9 > 0;
  end

  // ---------------- square root ----------------
  typedef struct packed {
    dw_t  nb;
    uq_t  den;
    uq_t  near;
    logic ok;
  } sq_side_t;

  typedef struct packed {
    uq_t  near;
    logic ok;
  } dv_side_t;

  logic [RTW-1:0] sroot;
  sq_side_t       sqs  [0:RTW-1];
  logic [RTW-1:0] sqv;

  rci_sqrt u_sqrt (
    .clk  (clk),
    .val  (disc10[DW-2:0]),
    .root (sroot)
  );

  always_ff @(posedge clk) begin
    sqs[0] <= '{nb: nb10, den: den10[DW-2:0], near: near[PRE],
                ok: ok10 && (disc10 > EPS_Q)};
    for (int i = 1; i < RTW; i++) sqs[i] <= sqs[i-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sqv <= '0;
    end else begin
      sqv <= {sqv[RTW-2:0], vld[PRE-1]};
    end
  end

  // ---------------- root numerators ----------------
  dw_t  n0, n1, sroot_q;
  uq_t  den11;
  logic v11;
  dv_side_t s11;

  assign sroot_q = dw_t'(sroot);

  always_ff @(posedge clk) begin
    n0    <= sadd(sqs[RTW-1].nb, sroot_q);
    n1    <= ssub(sqs[RTW-1].nb, sroot_q);
    den11 <= sqs[RTW-1].den;
    s11   <= '{near: sqs[RTW-1].near, ok: sqs[RTW-1].ok};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else begin
      v11 <= sqv[RTW-1];
    end
  end

  // ---------------- dividers ----------------
  dw_t t0, t1;

  rci_div u_div0 (.clk(clk), .num(n0), .den(den11), .quo(t0));
  rci_div u_div1 (.clk(clk), .num(n1), .den(den11), .quo(t1));

  dv_side_t       dvs [0:DVL-1];
  logic [DVL-1:0] dvv;

  always_ff @(posedge clk) begin
    dvs[0] <= s11;
    for (int i = 1; i < DVL; i++) dvs[i] <= dvs[i-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv <= '0;
    end else begin
      dvv <= {dvv[DVL-2:0], v11};
    end
  end

  // ---------------- root pick and result ----------------
  // nearer root t1 wins when it lies past epsilon
  dw_t  root;
  logic hit_c;

  assign root  = (t1 > EPS_Q) ? t1 : t0;
  assign hit_c = dvs[DVL-1].ok && (root > EPS_Q) &&
                 (root < dw_t'({1'b0, dvs[DVL-1].near}));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dvv[DVL-1];
    end
  end

  always_ff @(posedge clk) begin
    hit         <= hit_c;
    nearest_out <= hit_c ? root[DW-2:0] : dvs[DVL-1].near;
  end

  // ---------------- checks ----------------
  `RCI_ASSERT_IMP(a_latency, start && !busy, ##LAT done, "result strobe missing")
  `RCI_ASSERT_IMP(a_miss_keeps, done && !hit, nearest_out == $past(nearest_in, LAT),
                  "miss changed distance")
  `RCI_ASSERT_IMP(a_hit_positive, done && hit, nearest_out > EPS_Q[DW-2:0],
                  "hit at non-positive distance")
  `RCI_ASSERT_NXT(a_reject, dvv[DVL-1] && !dvs[DVL-1].ok, done && !hit,
                  "rejected ray reported as hit")

endmodule
